// ===== hw/rtl/gcol_pkg.sv =====
// Shared types, codes and default sizes for the grid cell occupancy lists.
package gcol_pkg;

  localparam int DEF_MAX_GRID_WIDTH  = 32;
  localparam int DEF_MAX_GRID_HEIGHT = 32;
  localparam int DEF_MAX_ENTITIES    = 64;

  // Entity pointer value that marks an empty head or a missing link.
  localparam logic [6:0] NO_ENT = 7'h7F;

  localparam logic [1:0] KIND_SET    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_COUNT  = 2'd2;
  localparam logic [1:0] KIND_LIST   = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_BADCELL = 2'd2;

  localparam logic [1:0] CFG_GRID_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_ENTITY_LIMIT = 2'd2;

  typedef struct packed {
    logic [6:0] head;
    logic [6:0] cnt;
  } cell_row_t;

  typedef struct packed {
    logic head;
    logic cnt;
  } cell_we_t;

  typedef struct packed {
    logic nxt;
    logic prv;
    logic cel;
  } ent_we_t;

endpackage

// ===== hw/rtl/grid_cell_occupancy_lists.sv =====
// Uniform grid occupancy lists: top level with request sequencer and result register.
// Set, remove and count give one result each; a list gives one result per member other
// than self, the final one marked last, or a single result when outside the grid or empty.
// Throughput: one request at a time, taken again the cycle after its final result loads;
// a list result that cannot leave because the consumer stalls holds the walk in place.
// Reset (rst_n low, synchronous) clears control and restores configuration defaults, then
// a clearing pass over all MAX_GRID_WIDTH*MAX_GRID_HEIGHT cells empties every cell.
module grid_cell_occupancy_lists import gcol_pkg::*; #(
  parameter int MAX_GRID_WIDTH  = DEF_MAX_GRID_WIDTH,
  parameter int MAX_GRID_HEIGHT = DEF_MAX_GRID_HEIGHT,
  parameter int MAX_ENTITIES    = DEF_MAX_ENTITIES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [5:0] in_entity,
  input  logic [7:0] in_cell_x,
  input  logic [7:0] in_cell_y,
  input  logic [6:0] in_self_entity,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [6:0] out_count,
  output logic       out_has_other,
  output logic [5:0] out_listed_entity,
  output logic       out_listed_valid,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int CELLS  = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
  localparam int CIDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int EA_W   = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;

  // One-hot sequencer states.
  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_DEC   = 14'b00000000000100,
    S_CHK   = 14'b00000000001000,
    S_UL1   = 14'b00000000010000,
    S_UL2   = 14'b00000000100000,
    S_LK1   = 14'b00000001000000,
    S_LK2   = 14'b00000010000000,
    S_LK3   = 14'b00000100000000,
    S_CNT   = 14'b00001000000000,
    S_LHEAD = 14'b00010000000000,
    S_WALK  = 14'b00100000000000,
    S_FLUSH = 14'b01000000000000,
    S_RESP  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [5:0] grid_width_r, grid_height_r;
  logic [6:0] entity_limit_r;

  // Request held for the duration of its processing.
  logic [1:0] kind_r;
  logic [5:0] ent_r;
  logic [7:0] cx_r, cy_r;
  logic [6:0] self_r;

  // Working registers.
  logic [CIDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [CIDX_W-1:0] cidx_r, cidx_nxt;
  logic [CIDX_W-1:0] oc_r, oc_nxt;
  logic [6:0]        p_r, p_nxt, n_r, n_nxt, h_r, h_nxt;
  logic [6:0]        cur_r, cur_nxt;
  logic [5:0]        hold_r, hold_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic [MAX_ENTITIES-1:0] in_cell_r, in_cell_nxt;

  // Pending response, moved into the output register in S_RESP.
  logic [1:0] rs_status_r, rs_status_nxt;
  logic [6:0] rs_count_r, rs_count_nxt;
  logic       rs_other_r, rs_other_nxt;
  logic [5:0] rs_ent_r, rs_ent_nxt;
  logic       rs_lv_r, rs_lv_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r;
  logic [6:0] out_count_r;
  logic       out_has_other_r;
  logic [5:0] out_listed_entity_r;
  logic       out_listed_valid_r;
  logic       out_last_r;

  // Load request for the output register from the sequencer.
  logic       ld;
  logic [1:0] ld_status;
  logic [6:0] ld_count;
  logic       ld_other;
  logic [5:0] ld_ent;
  logic       ld_lv;
  logic       ld_last;
  logic       can_emit;

  // Memory ports.
  logic [CIDX_W-1:0] c_rd_addr, c_wr_addr;
  cell_row_t         c_q, c_wd;
  cell_we_t          c_we;
  logic [EA_W-1:0]   e_rd_addr, e_wr_addr;
  logic [6:0]        e_q_nxt, e_q_prv, e_wd_nxt, e_wd_prv;
  logic [CIDX_W-1:0] e_q_cel, e_wd_cel;
  ent_we_t           e_we;

  // Effective sizes and cell index arithmetic.
  logic [7:0]  w_eff, h_eff, wm1, hm1, xs, ys, xq, yq;
  logic [6:0]  lim_eff;
  logic        ent_ign, grid_zero, q_out;
  logic [15:0] idx_set, idx_qry;
  logic        member;

  gcol_cell_mem #(.CELLS(CELLS), .CIDX_W(CIDX_W)) u_cell_mem (
    .clk     (clk),
    .rd_addr (c_rd_addr),
    .rd_q    (c_q),
    .wr_en   (c_we),
    .wr_addr (c_wr_addr),
    .wr_data (c_wd)
  );

  gcol_ent_mem #(.ENTS(MAX_ENTITIES), .EA_W(EA_W), .CIDX_W(CIDX_W)) u_ent_mem (
    .clk     (clk),
    .rd_addr (e_rd_addr),
    .rd_nxt  (e_q_nxt),
    .rd_prv  (e_q_prv),
    .rd_cel  (e_q_cel),
    .wr_en   (e_we),
    .wr_addr (e_wr_addr),
    .wr_nxt  (e_wd_nxt),
    .wr_prv  (e_wd_prv),
    .wr_cel  (e_wd_cel)
  );

  // The grid in use is the configured size capped at the built size.
  always_comb begin
    w_eff = ({2'b00, grid_width_r} < 8'(MAX_GRID_WIDTH)) ?
            {2'b00, grid_width_r} : 8'(MAX_GRID_WIDTH);
    h_eff = ({2'b00, grid_height_r} < 8'(MAX_GRID_HEIGHT)) ?
            {2'b00, grid_height_r} : 8'(MAX_GRID_HEIGHT);
    lim_eff = (entity_limit_r < 7'(MAX_ENTITIES)) ? entity_limit_r : 7'(MAX_ENTITIES);
    wm1 = w_eff - 8'd1;
    hm1 = h_eff - 8'd1;
    ent_ign   = ({1'b0, ent_r} >= lim_eff);
    grid_zero = (w_eff == 8'd0) || (h_eff == 8'd0);
    // Set clamps negative coordinates to zero and large ones to the last column or row.
    xs = cx_r[7] ? 8'd0 : ((cx_r > wm1) ? wm1 : cx_r);
    ys = cy_r[7] ? 8'd0 : ((cy_r > hm1) ? hm1 : cy_r);
    xq = cx_r;
    yq = cy_r;
    q_out = cx_r[7] || cy_r[7] || (cx_r >= w_eff) || (cy_r >= h_eff);
    idx_set = ys * w_eff + {8'd0, xs};
    idx_qry = yq * w_eff + {8'd0, xq};
    // Self never matches when negative, since its sign bit is set.
    member = (cur_r != self_r);
  end

  assign can_emit = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cidx_nxt      = cidx_r;
    oc_nxt        = oc_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    h_nxt         = h_r;
    cur_nxt       = cur_r;
    hold_nxt      = hold_r;
    hold_v_nxt    = hold_v_r;
    in_cell_nxt   = in_cell_r;
    rs_status_nxt = rs_status_r;
    rs_count_nxt  = rs_count_r;
    rs_other_nxt  = rs_other_r;
    rs_ent_nxt    = rs_ent_r;
    rs_lv_nxt     = rs_lv_r;

    ld        = 1'b0;
    ld_status = rs_status_r;
    ld_count  = rs_count_r;
    ld_other  = rs_other_r;
    ld_ent    = rs_ent_r;
    ld_lv     = rs_lv_r;
    ld_last   = 1'b1;

    c_rd_addr = cidx_r;
    c_we      = '0;
    c_wr_addr = cidx_r;
    c_wd      = '0;
    e_rd_addr = cur_r[EA_W-1:0];
    e_we      = '0;
    e_wr_addr = ent_r[EA_W-1:0];
    e_wd_nxt  = n_r;
    e_wd_prv  = p_r;
    e_wd_cel  = cidx_r;

    unique case (state_r)
      S_CLR: begin
        c_we      = '{head: 1'b1, cnt: 1'b1};
        c_wr_addr = clr_cnt_r;
        c_wd      = '{head: NO_ENT, cnt: 7'd0};
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CIDX_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        rs_status_nxt = ST_DONE;
        rs_count_nxt  = 7'd0;
        rs_other_nxt  = 1'b0;
        rs_ent_nxt    = 6'd0;
        rs_lv_nxt     = 1'b0;
        e_rd_addr     = ent_r[EA_W-1:0];
        unique case (kind_r) inside
          KIND_SET, KIND_REMOVE: begin
            cidx_nxt = idx_set[CIDX_W-1:0];
            if (ent_ign || ((kind_r == KIND_SET) && grid_zero)) begin
              rs_status_nxt = ST_IGNORED;
              state_nxt     = S_RESP;
            end else begin
              state_nxt = S_CHK;
            end
          end
          default: begin
            cidx_nxt  = idx_qry[CIDX_W-1:0];
            c_rd_addr = idx_qry[CIDX_W-1:0];
            if (q_out) begin
              rs_status_nxt = ST_BADCELL;
              state_nxt     = S_RESP;
            end else if (kind_r == KIND_COUNT) begin
              state_nxt = S_CNT;
            end else begin
              state_nxt = S_LHEAD;
            end
          end
        endcase
      end
      S_CHK: begin
        p_nxt  = e_q_prv;
        n_nxt  = e_q_nxt;
        oc_nxt = e_q_cel;
        if (in_cell_r[ent_r[EA_W-1:0]]) begin
          if ((kind_r == KIND_SET) && (e_q_cel == cidx_r)) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_UL1;
          end
        end else if (kind_r == KIND_SET) begin
          state_nxt = S_LK1;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_UL1: begin
        // Bypass the entity: its predecessor, or the cell head, takes its successor.
        if (p_r != NO_ENT) begin
          e_we      = '{nxt: 1'b1, prv: 1'b0, cel: 1'b0};
          e_wr_addr = p_r[EA_W-1:0];
          e_wd_nxt  = n_r;
        end else begin
          c_we      = '{head: 1'b1, cnt: 1'b0};
          c_wr_addr = oc_r;
          c_wd      = '{head: n_r, cnt: 7'd0};
        end
        c_rd_addr = oc_r;
        state_nxt = S_UL2;
      end
      S_UL2: begin
        if (n_r != NO_ENT) begin
          e_we      = '{nxt: 1'b0, prv: 1'b1, cel: 1'b0};
          e_wr_addr = n_r[EA_W-1:0];
          e_wd_prv  = p_r;
        end
        c_we      = '{head: 1'b0, cnt: 1'b1};
        c_wr_addr = oc_r;
        c_wd      = '{head: NO_ENT, cnt: (c_q.cnt != 7'd0) ? c_q.cnt - 7'd1 : c_q.cnt};
        in_cell_nxt[ent_r[EA_W-1:0]] = 1'b0;
        state_nxt = (kind_r == KIND_SET) ? S_LK1 : S_RESP;
      end
      S_LK1: begin
        c_rd_addr = cidx_r;
        state_nxt = S_LK2;
      end
      S_LK2: begin
        // The entity becomes the new head of its cell.
        h_nxt     = c_q.head;
        e_we      = '{nxt: 1'b1, prv: 1'b1, cel: 1'b1};
        e_wr_addr = ent_r[EA_W-1:0];
        e_wd_nxt  = c_q.head;
        e_wd_prv  = NO_ENT;
        e_wd_cel  = cidx_r;
        c_we      = '{head: 1'b1, cnt: 1'b1};
        c_wr_addr = cidx_r;
        c_wd      = '{head: {1'b0, ent_r}, cnt: c_q.cnt + 7'd1};
        in_cell_nxt[ent_r[EA_W-1:0]] = 1'b1;
        state_nxt = S_LK3;
      end
      S_LK3: begin
        if (h_r != NO_ENT) begin
          e_we      = '{nxt: 1'b0, prv: 1'b1, cel: 1'b0};
          e_wr_addr = h_r[EA_W-1:0];
          e_wd_prv  = {1'b0, ent_r};
        end
        state_nxt = S_RESP;
      end
      S_CNT: begin
        // Members are distinct, so a second member always differs from self.
        rs_count_nxt = c_q.cnt;
        rs_other_nxt = ((c_q.head != NO_ENT) && (c_q.head != self_r)) ||
                       (c_q.cnt >= 7'd2);
        state_nxt    = S_RESP;
      end
      S_LHEAD: begin
        hold_v_nxt = 1'b0;
        if (c_q.head == NO_ENT) begin
          state_nxt = S_RESP;
        end else begin
          cur_nxt   = c_q.head;
          e_rd_addr = c_q.head[EA_W-1:0];
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // The entity memory output holds the links of the current member. A member
        // waits in the hold register until the next one shows whether it is last.
        if (member && hold_v_r && !can_emit) begin
          e_rd_addr = cur_r[EA_W-1:0];
        end else begin
          if (member && hold_v_r) begin
            ld      = 1'b1;
            ld_status = ST_DONE;
            ld_count  = 7'd0;
            ld_other  = 1'b0;
            ld_ent    = hold_r;
            ld_lv     = 1'b1;
            ld_last   = 1'b0;
          end
          if (member) begin
            hold_nxt   = cur_r[5:0];
            hold_v_nxt = 1'b1;
          end
          if (e_q_nxt == NO_ENT) begin
            state_nxt = S_FLUSH;
          end else begin
            cur_nxt   = e_q_nxt;
            e_rd_addr = e_q_nxt[EA_W-1:0];
          end
        end
      end
      S_FLUSH: begin
        rs_ent_nxt = hold_v_r ? hold_r : 6'd0;
        rs_lv_nxt  = hold_v_r;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (can_emit) begin
          ld        = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLR;
      clr_cnt_r      <= '0;
      in_cell_r      <= '0;
      hold_v_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      grid_width_r   <= 6'd32;
      grid_height_r  <= 6'd32;
      entity_limit_r <= 7'd64;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      in_cell_r   <= in_cell_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:   grid_width_r   <= cfg_data[5:0];
          CFG_GRID_HEIGHT:  grid_height_r  <= cfg_data[5:0];
          CFG_ENTITY_LIMIT: entity_limit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      ent_r  <= in_entity;
      cx_r   <= in_cell_x;
      cy_r   <= in_cell_y;
      self_r <= in_self_entity;
    end
    cidx_r      <= cidx_nxt;
    oc_r        <= oc_nxt;
    p_r         <= p_nxt;
    n_r         <= n_nxt;
    h_r         <= h_nxt;
    cur_r       <= cur_nxt;
    hold_r      <= hold_nxt;
    rs_status_r <= rs_status_nxt;
    rs_count_r  <= rs_count_nxt;
    rs_other_r  <= rs_other_nxt;
    rs_ent_r    <= rs_ent_nxt;
    rs_lv_r     <= rs_lv_nxt;
    if (ld) begin
      out_status_r        <= ld_status;
      out_count_r         <= ld_count;
      out_has_other_r     <= ld_other;
      out_listed_entity_r <= ld_ent;
      out_listed_valid_r  <= ld_lv;
      out_last_r          <= ld_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_count         = out_count_r;
  assign out_has_other     = out_has_other_r;
  assign out_listed_entity = out_listed_entity_r;
  assign out_listed_valid  = out_listed_valid_r;
  assign out_last          = out_last_r;

endmodule

// ===== hw/rtl/gcol_cell_mem.sv =====
// Per-cell memory holding the list head and the member count, with field write enables.
module gcol_cell_mem import gcol_pkg::*; #(
  parameter int CELLS  = 1024,
  parameter int CIDX_W = 10
) (
  input  logic              clk,
  input  logic [CIDX_W-1:0] rd_addr,
  output cell_row_t         rd_q,
  input  cell_we_t          wr_en,
  input  logic [CIDX_W-1:0] wr_addr,
  input  cell_row_t         wr_data
);

  cell_row_t mem [CELLS];
  cell_row_t rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en.head) begin
      mem[wr_addr].head <= wr_data.head;
    end
    if (wr_en.cnt) begin
      mem[wr_addr].cnt <= wr_data.cnt;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign rd_q = rd_q_r;

endmodule

// ===== hw/rtl/gcol_ent_mem.sv =====
// Per-entity memory holding next link, previous link and current cell.
module gcol_ent_mem import gcol_pkg::*; #(
  parameter int ENTS   = 64,
  parameter int EA_W   = 6,
  parameter int CIDX_W = 10
) (
  input  logic              clk,
  input  logic [EA_W-1:0]   rd_addr,
  output logic [6:0]        rd_nxt,
  output logic [6:0]        rd_prv,
  output logic [CIDX_W-1:0] rd_cel,
  input  ent_we_t           wr_en,
  input  logic [EA_W-1:0]   wr_addr,
  input  logic [6:0]        wr_nxt,
  input  logic [6:0]        wr_prv,
  input  logic [CIDX_W-1:0] wr_cel
);

  logic [6:0]        nxt_mem [ENTS];
  logic [6:0]        prv_mem [ENTS];
  logic [CIDX_W-1:0] cel_mem [ENTS];
  logic [6:0]        nxt_q_r;
  logic [6:0]        prv_q_r;
  logic [CIDX_W-1:0] cel_q_r;

  always_ff @(posedge clk) begin
    if (wr_en.nxt) begin
      nxt_mem[wr_addr] <= wr_nxt;
    end
    if (wr_en.prv) begin
      prv_mem[wr_addr] <= wr_prv;
    end
    if (wr_en.cel) begin
      cel_mem[wr_addr] <= wr_cel;
    end
    nxt_q_r <= nxt_mem[rd_addr];
    prv_q_r <= prv_mem[rd_addr];
    cel_q_r <= cel_mem[rd_addr];
  end

  assign rd_nxt = nxt_q_r;
  assign rd_prv = prv_q_r;
  assign rd_cel = cel_q_r;

endmodule

// ===== hw/rtl/gcol_checker.sv =====
// Port-level checker for the grid cell occupancy lists and its bind.
module gcol_checker import gcol_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [6:0] out_count,
  input logic       out_has_other,
  input logic [5:0] out_listed_entity,
  input logic       out_listed_valid,
  input logic       out_last
);

  // A stalled result stays valid and keeps its status, listed entity and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_listed_entity) &&
    $stable(out_status) && $stable(out_last))
    else $error("stalled result changed");

  // The cell clearing pass keeps the input closed right after reset.
  a_clear: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("request taken during clearing pass");

  // One request is processed at a time.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // Listed members only appear in successful results.
  a_list_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_listed_valid |-> out_status == ST_DONE && out_count == 7'd0)
    else $error("listed member with bad status");

  // Ignored and bad-cell results are single and final.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_last && !out_has_other)
    else $error("error result not final");

endmodule

bind grid_cell_occupancy_lists gcol_checker u_gcol_checker (.*);

// ===== bench/gcol_occupancy_checker.sv =====
// Checker for the grid cell occupancy lists: predicts every result and compares it.
module gcol_occupancy_checker import gcol_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [5:0] in_entity,
  input  logic [7:0] in_cell_x,
  input  logic [7:0] in_cell_y,
  input  logic [6:0] in_self_entity,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_status,
  input  logic [6:0] out_count,
  input  logic       out_has_other,
  input  logic [5:0] out_listed_entity,
  input  logic       out_listed_valid,
  input  logic       out_last,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  output int         fail_count,
  output int         pending_count
);

  localparam int GW = DEF_MAX_GRID_WIDTH;
  localparam int GH = DEF_MAX_GRID_HEIGHT;
  localparam int NE = DEF_MAX_ENTITIES;
  localparam logic [10:0] NOWHERE = 11'h7FF;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] count;
    logic       has_other;
    logic [5:0] ent;
    logic       valid;
    logic       last;
  } occ_result_t;

  logic [6:0]  cell_head  [GW*GH];
  logic [6:0]  cell_cnt   [GW*GH];
  logic [6:0]  ent_next   [NE];
  logic [6:0]  ent_prev   [NE];
  logic [10:0] ent_cell   [NE];
  logic [5:0]  grid_w, grid_h;
  logic [6:0]  ent_lim;

  occ_result_t pending_results[$];

  // Appends one expected result behind those already waiting.
  function automatic void expect_result(occ_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void clear_grid();
    foreach (cell_head[i]) begin
      cell_head[i] = NO_ENT;
      cell_cnt[i]  = '0;
    end
    foreach (ent_cell[i]) begin
      ent_next[i] = '0;
      ent_prev[i] = '0;
      ent_cell[i] = NOWHERE;
    end
    grid_w  = 6'd32;
    grid_h  = 6'd32;
    ent_lim = 7'd64;
  endfunction

  function automatic void unlink_entity(int e);
    int c, p, n;
    c = ent_cell[e];
    if (ent_cell[e] == NOWHERE) return;
    p = ent_prev[e];
    n = ent_next[e];
    if (p < NE) ent_next[p] = 7'(n);
    else cell_head[c] = 7'(n);
    if (n < NE) ent_prev[n] = 7'(p);
    if (cell_cnt[c] > 0) cell_cnt[c] = cell_cnt[c] - 7'd1;
    ent_cell[e] = NOWHERE;
  endfunction

  function automatic occ_result_t mk(logic [1:0] st, int cnt, bit oth, int ent, bit v, bit l);
    occ_result_t r;
    r.status = st; r.count = 7'(cnt); r.has_other = oth;
    r.ent = 6'(ent); r.valid = v; r.last = l;
    return r;
  endfunction

  // Works out the results of one request and applies its effect on the grid.
  function automatic void predict_occupancy_results(logic [1:0] kind, logic [5:0] ent,
                                                    logic [7:0] x, logic [7:0] y,
                                                    logic [6:0] self_e);
    int w, h, lim, cx, cy, sf, c, i, steps, hd;
    bit other;
    occ_result_t members[$];
    w   = (grid_w < GW) ? int'(grid_w) : GW;
    h   = (grid_h < GH) ? int'(grid_h) : GH;
    lim = (ent_lim < NE) ? int'(ent_lim) : NE;
    cx  = int'($signed(x));
    cy  = int'($signed(y));
    sf  = int'($signed(self_e));
    case (kind)
      KIND_SET: begin
        if (ent >= lim || w == 0 || h == 0) begin
          expect_result(mk(ST_IGNORED, 0, 0, 0, 0, 1));
        end else begin
          if (cx < 0) cx = 0;
          if (cx > w - 1) cx = w - 1;
          if (cy < 0) cy = 0;
          if (cy > h - 1) cy = h - 1;
          c = cy * w + cx;
          if (ent_cell[ent] != 11'(c)) begin
            unlink_entity(ent);
            hd = cell_head[c];
            ent_next[ent] = 7'(hd);
            ent_prev[ent] = NO_ENT;
            if (hd < NE) ent_prev[hd] = 7'(ent);
            cell_head[c] = 7'(ent);
            cell_cnt[c]  = cell_cnt[c] + 7'd1;
            ent_cell[ent] = 11'(c);
          end
          expect_result(mk(ST_DONE, 0, 0, 0, 0, 1));
        end
      end
      KIND_REMOVE: begin
        if (ent >= lim) begin
          expect_result(mk(ST_IGNORED, 0, 0, 0, 0, 1));
        end else begin
          unlink_entity(ent);
          expect_result(mk(ST_DONE, 0, 0, 0, 0, 1));
        end
      end
      default: begin
        if (cx < 0 || cx >= w || cy < 0 || cy >= h) begin
          expect_result(mk(ST_BADCELL, 0, 0, 0, 0, 1));
        end else begin
          c = cy * w + cx;
          i = cell_head[c];
          steps = 0;
          other = 0;
          while (i < NE && steps < NE) begin
            if (i != sf) begin
              other = 1;
              members.insert(members.size(), mk(ST_DONE, 0, 0, i, 1, 0));
            end
            i = ent_next[i];
            steps++;
          end
          if (kind == KIND_COUNT) begin
            expect_result(mk(ST_DONE, cell_cnt[c], other, 0, 0, 1));
          end else if (members.size() == 0) begin
            expect_result(mk(ST_DONE, 0, 0, 0, 0, 1));
          end else begin
            members[members.size()-1].last = 1'b1;
            foreach (members[k]) expect_result(members[k]);
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    occ_result_t got, want;
    if (!rst_n) begin
      clear_grid();
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_status, out_count, out_has_other, out_listed_entity,
               out_listed_valid, out_last};
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Unexpected result: status=%0d count=%0d other=%0b ent=%0d %s=%0b last=%0b",
                     got.status, got.count, got.has_other, got.ent, "valid",
                     got.valid, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("Mismatch: expected status=%0d count=%0d other=%0b ent=%0d",
                       want.status, want.count, want.has_other, want.ent);
              $display("  expected valid=%0b last=%0b", want.valid, want.last);
              $display("  got status=%0d count=%0d other=%0b ent=%0d valid=%0b last=%0b",
                       got.status, got.count, got.has_other, got.ent, got.valid, got.last);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_WIDTH:   grid_w  = cfg_data[5:0];
          CFG_GRID_HEIGHT:  grid_h  = cfg_data[5:0];
          CFG_ENTITY_LIMIT: ent_lim = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_occupancy_results(in_kind, in_entity, in_cell_x, in_cell_y, in_self_entity);
    end
    pending_count = pending_results.size();
  end

endmodule

// ===== bench/tb_grid_cell_occupancy_lists.sv =====
// Testbench top for the grid cell occupancy lists: stimulus, flow control and verdict.
module tb_grid_cell_occupancy_lists;
  import gcol_pkg::*;

  // The run is bounded well above the slowest legal run, including the clearing pass.
  localparam int CYCLE_LIMIT = 600000;

  logic       clk, rst_n;
  logic       in_valid, in_ready;
  logic [1:0] in_kind;
  logic [5:0] in_entity;
  logic [7:0] in_cell_x, in_cell_y;
  logic [6:0] in_self_entity;
  logic       out_valid, out_ready;
  logic [1:0] out_status;
  logic [6:0] out_count;
  logic       out_has_other;
  logic [5:0] out_listed_entity;
  logic       out_listed_valid, out_last;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;
  int         fail_count, pending_count;
  int         cycles;

  // Shared between the request driver and the result consumer.
  bit calm;      // no idling on either side while set
  bit hold_req;  // asks the consumer for one long hold-off

  grid_cell_occupancy_lists u_dut (.*);

  gcol_occupancy_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle counter that ends a hung run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // The consumer stalls at random, except during the calm stretch. When asked, it holds
  // off ready so that a result stalls and the block stops taking requests.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else if (hold_req) begin
        hold_req  = 0;
        hold_left = 400;
        out_ready = 1'b0;
      end else begin
        out_ready = calm ? 1'b1 : ($urandom_range(99) >= 33);
      end
    end
  end

  // Offers one request and returns at the falling edge after it was taken. Valid stays
  // high into the next request unless a random gap drops it.
  task automatic send_request(logic [1:0] kind, logic [5:0] ent, logic [7:0] x,
                              logic [7:0] y, logic [6:0] self_e);
    if (!calm && $urandom_range(99) < 33) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_kind        = kind;
    in_entity      = ent;
    in_cell_x      = x;
    in_cell_y      = y;
    in_self_entity = self_e;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Configuration is changed only once every expected result is back, plus a short margin.
  task automatic set_grid(logic [6:0] w, logic [6:0] h, logic [6:0] lim);
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_we = 1'b1; cfg_index = CFG_GRID_WIDTH;   cfg_data = w;   @(negedge clk);
    cfg_index = CFG_GRID_HEIGHT;  cfg_data = h;   @(negedge clk);
    cfg_index = CFG_ENTITY_LIMIT; cfg_data = lim; @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random request with most traffic on a few cells near the origin, so lists grow long.
  task automatic random_request();
    logic [1:0] kind;
    logic [7:0] x, y;
    logic [6:0] self_e;
    int sel;
    sel = $urandom_range(99);
    kind = (sel < 40) ? KIND_SET : (sel < 55) ? KIND_REMOVE :
           (sel < 75) ? KIND_COUNT : KIND_LIST;
    sel = $urandom_range(99);
    if (sel < 60) begin
      x = 8'($urandom_range(2));
      y = 8'($urandom_range(2));
    end else if (sel < 80) begin
      x = 8'($urandom);
      y = 8'($urandom);
    end else begin
      x = 8'(int'(u_chk.grid_w) - 1 + int'($urandom_range(2)) - 1);
      y = 8'(int'(u_chk.grid_h) - 1 + int'($urandom_range(2)) - 1);
    end
    sel = $urandom_range(99);
    self_e = (sel < 40) ? 7'h7F : (sel < 80) ? 7'($urandom_range(63)) : 7'($urandom);
    send_request(kind, 6'($urandom), x, y, self_e);
  endtask

  initial begin
    logic [6:0] phase_w[8]   = '{7'd32, 7'd63, 7'd5,  7'd8,  7'd0,  7'd32, 7'd1,  7'd32};
    logic [6:0] phase_h[8]   = '{7'd32, 7'd63, 7'd3,  7'd8,  7'd32, 7'd0,  7'd1,  7'd32};
    logic [6:0] phase_lim[8] = '{7'd64, 7'd127, 7'd64, 7'd10, 7'd64, 7'd0, 7'd64, 7'd64};
    rst_n = 1'b0;
    in_valid = 1'b0; in_kind = KIND_SET; in_entity = '0;
    in_cell_x = '0; in_cell_y = '0; in_self_entity = '0;
    cfg_we = 1'b0; cfg_index = CFG_GRID_WIDTH; cfg_data = '0;
    calm = 0; hold_req = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    // Let the clearing pass finish before the first configuration write.
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    set_grid(phase_w[0], phase_h[0], phase_lim[0]);

    // Directed part: clamping at both corners, repeat set to the same cell, self
    // exclusion, empty list, queries outside the grid, and removal of an absent entity.
    send_request(KIND_SET,    6'd0,  8'h80, 8'h80, 7'h7F);
    send_request(KIND_SET,    6'd63, 8'h7F, 8'h7F, 7'h7F);
    send_request(KIND_SET,    6'd1,  8'd0,  8'd0,  7'h7F);
    send_request(KIND_SET,    6'd1,  8'd0,  8'd0,  7'h7F);
    send_request(KIND_SET,    6'd2,  8'd0,  8'd0,  7'h7F);
    send_request(KIND_COUNT,  6'd0,  8'd0,  8'd0,  7'h7F);
    send_request(KIND_COUNT,  6'd0,  8'd0,  8'd0,  7'd1);
    send_request(KIND_LIST,   6'd0,  8'd0,  8'd0,  7'd1);
    send_request(KIND_LIST,   6'd0,  8'd0,  8'd0,  7'h40);
    send_request(KIND_LIST,   6'd0,  8'd5,  8'd5,  7'h7F);
    send_request(KIND_COUNT,  6'd0,  8'hFF, 8'd0,  7'h7F);
    send_request(KIND_LIST,   6'd0,  8'd32, 8'd0,  7'h7F);
    send_request(KIND_COUNT,  6'd0,  8'd0,  8'h7F, 7'h7F);
    send_request(KIND_COUNT,  6'd0,  8'd31, 8'd31, 7'd63);
    send_request(KIND_LIST,   6'd0,  8'd31, 8'd31, 7'd63);
    send_request(KIND_SET,    6'd1,  8'd31, 8'd31, 7'h7F);
    send_request(KIND_LIST,   6'd0,  8'd31, 8'd31, 7'd63);
    send_request(KIND_REMOVE, 6'd1,  8'd0,  8'd0,  7'h7F);
    send_request(KIND_REMOVE, 6'd1,  8'd0,  8'd0,  7'h7F);
    send_request(KIND_REMOVE, 6'd0,  8'd0,  8'd0,  7'h7F);
    send_request(KIND_LIST,   6'd0,  8'd0,  8'd0,  7'h7F);

    // Random phases; the grid is reshaped while occupied and the limit is lowered.
    for (int p = 0; p < 8; p++) begin
      if (p > 0) set_grid(phase_w[p], phase_h[p], phase_lim[p]);
      calm = (p == 3);
      if (p == 2) hold_req = 1;
      repeat (30) random_request();
    end

    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
